// File: rtl/core/ads_pkg.sv
// ----------------------------------------------------------------------------
// ads_pkg
// Shared types and constants for the approach docking supervisor: beat
// layouts, phase and event codes, register indexes and small helpers.
// ----------------------------------------------------------------------------
package ads_pkg;

    // Field widths fixed by the beat layout.
    localparam int ERROR_BITS     = 16;
    localparam int TIME_BITS      = 32;
    localparam int TOL_BITS       = 15;
    localparam int MS_BITS        = 16;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 3;
    localparam int KIND_BITS      = 3;

    // Register reset values (Q3.12 tolerances, millisecond times).
    localparam logic [TOL_BITS-1:0] X_TOL_RESET       = TOL_BITS'(123);
    localparam logic [TOL_BITS-1:0] ANGLE_TOL_RESET   = TOL_BITS'(328);
    localparam logic [MS_BITS-1:0]  DWELL_TIME_RESET  = MS_BITS'(2000);
    localparam logic [MS_BITS-1:0]  ALIGN_TMO_RESET   = MS_BITS'(5000);
    localparam logic [MS_BITS-1:0]  RANGE_TMO_RESET   = MS_BITS'(2000);
    localparam logic [MS_BITS-1:0]  RANGE_BRIDGE_RESET = MS_BITS'(200);
    localparam logic [MS_BITS-1:0]  CONV_HOLD_RESET   = MS_BITS'(500);

    // Event codes carried in the kind field.
    typedef enum logic [KIND_BITS-1:0] {
        KIND_TICK  = 3'd0,
        KIND_RANGE = 3'd1,
        KIND_ANGLE = 3'd2,
        KIND_START = 3'd3,
        KIND_STOP  = 3'd4
    } kind_t;

    // Internal supervisor phase.
    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_APPROACH = 3'd1,
        PH_ALIGN    = 3'd2,
        PH_DWELL    = 3'd3,
        PH_DONE     = 3'd4
    } phase_t;

    // Phase as reported in a result beat.
    typedef enum logic [1:0] {
        OPH_APPROACH = 2'd0,
        OPH_ALIGN    = 2'd1,
        OPH_DWELL    = 2'd2,
        OPH_DONE     = 2'd3
    } out_phase_t;

    // Sticky outcome code.
    typedef enum logic [1:0] {
        OUT_RUNNING   = 2'd0,
        OUT_SUCCEEDED = 2'd1,
        OUT_FAILED    = 2'd2
    } outcome_t;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_X_TOL        = 3'd0,
        CFG_ANGLE_TOL    = 3'd1,
        CFG_DWELL_TIME   = 3'd2,
        CFG_ALIGN_TMO    = 3'd3,
        CFG_RANGE_TMO    = 3'd4,
        CFG_RANGE_BRIDGE = 3'd5,
        CFG_CONV_HOLD    = 3'd6
    } cfg_index_t;

    // Input beat.
    typedef struct packed {
        logic [KIND_BITS-1:0]         kind;
        logic [TIME_BITS-1:0]         now_ms;
        logic                         report_valid;
        logic signed [ERROR_BITS-1:0] x_error_in;
        logic signed [ERROR_BITS-1:0] theta_error_in;
    } in_beat_t;

    // Result beat.
    typedef struct packed {
        logic [1:0]                   phase;
        logic                         ctrl_publish;
        logic                         ctrl_valid;
        logic signed [ERROR_BITS-1:0] ctrl_x;
        logic signed [ERROR_BITS-1:0] ctrl_theta;
        logic signed [ERROR_BITS-1:0] ctrl_initial_dist;
        logic                         range_held;
        logic [1:0]                   outcome;
    } out_beat_t;

    // Magnitude of a signed error as an unsigned value; the most negative
    // code gives exactly half the range.
    function automatic logic [ERROR_BITS-1:0] err_mag(input logic signed [ERROR_BITS-1:0] v);
        logic [ERROR_BITS-1:0] u;
        u = v;
        return v[ERROR_BITS-1] ? (~u + ERROR_BITS'(1)) : u;
    endfunction

endpackage

// File: rtl/core/approach_docking_supervisor_unit.sv
// ----------------------------------------------------------------------------
// approach_docking_supervisor_unit
// Phase supervisor for a close approach: holds range and heading reports,
// applies tolerances, hold times and timeouts, and reports the control error.
// ----------------------------------------------------------------------------
// Usage: events enter on the s_ channel (s_valid, s_ready, s_data) as
// ticks, range reports, angle reports, start and stop beats, each carrying a
// wrapping millisecond timestamp. Only a tick outside idle produces a result
// beat on the m_ channel (m_valid, m_ready, m_data); every other event
// updates the held state silently. Tolerances and times are written through
// the cfg_ channel (cfg_valid, cfg_ready, cfg_index, cfg_data), which is
// always ready; writes to an index beyond the list are dropped.
// An accepted event waits in the input register while the decision logic
// feeds the result register, which loads when the receiver has taken the
// previous beat or none is held. Throughput: one event per cycle while the
// result register is free or drained, set by the single pass through the
// decision logic between those two registers.
// Reset (aresetn low, synchronous) returns the block to idle with cleared
// sensor state, no outcome and the default tolerances and times.
// When the receiver stalls, the result register holds its beat, the decision
// stage freezes, and s_ready drops once the input register is occupied.
// ----------------------------------------------------------------------------
module approach_docking_supervisor_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Event channel
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  ads_pkg::in_beat_t                     s_data,
    // Result channel
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output ads_pkg::out_beat_t                    m_data,
    // Configuration channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [ads_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [ads_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    localparam int EB = ads_pkg::ERROR_BITS;
    localparam int TB = ads_pkg::TIME_BITS;
    localparam int MB = ads_pkg::MS_BITS;
    localparam int TL = ads_pkg::TOL_BITS;

    // Configuration registers
    logic [TL-1:0] x_tol_reg;
    logic [TL-1:0] angle_tol_reg;
    logic [MB-1:0] dwell_time_reg;
    logic [MB-1:0] align_tmo_reg;
    logic [MB-1:0] range_tmo_reg;
    logic [MB-1:0] range_bridge_reg;
    logic [MB-1:0] conv_hold_reg;

    // Pipeline registers
    logic               in_valid_reg;
    ads_pkg::in_beat_t  in_reg;
    logic               out_valid_reg;
    ads_pkg::out_beat_t out_reg;

    // Supervisor state and next values
    ads_pkg::phase_t phase_reg, phase_next;
    logic            have_range_reg, have_range_next;
    logic            range_rvalid_reg, range_rvalid_next;
    logic signed [EB-1:0] range_x_reg, range_x_next;
    logic [TB-1:0]   valid_time_reg, valid_time_next;
    logic signed [EB-1:0] good_x_reg, good_x_next;
    logic            initial_known_reg, initial_known_next;
    logic signed [EB-1:0] initial_range_reg, initial_range_next;
    logic            angle_known_reg, angle_known_next;
    logic signed [EB-1:0] held_angle_reg, held_angle_next;
    logic            conv_pending_reg, conv_pending_next;
    logic [TB-1:0]   conv_start_reg, conv_start_next;
    logic [TB-1:0]   align_start_reg, align_start_next;
    logic [TB-1:0]   dwell_start_reg, dwell_start_next;
    logic            success_reg, success_next;
    logic            failure_reg, failure_next;

    // Handshake and stage control
    logic advance;
    logic step;
    logic active;
    logic emit;
    ads_pkg::out_beat_t res;

    // Decision terms
    logic [TB-1:0]        since;
    logic [TB-1:0]        conv_age;
    logic [TB-1:0]        align_age;
    logic [TB-1:0]        dwell_age;
    logic                 range_ok;
    logic                 bridged;
    logic                 xvalid;
    logic signed [EB-1:0] x_sel;
    logic                 timed_out;
    logic                 x_in_tol;
    logic                 angle_in_tol;
    logic                 t_in_tol;

    // The whole pipeline moves when the result register is free or drained.
    assign advance   = !out_valid_reg || m_ready;
    assign s_ready   = !in_valid_reg || advance;
    assign step      = in_valid_reg && advance;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    // A tick is handled in any phase other than idle.
    assign active = (phase_reg == ads_pkg::PH_APPROACH) || (phase_reg == ads_pkg::PH_ALIGN) ||
                    (phase_reg == ads_pkg::PH_DWELL) || (phase_reg == ads_pkg::PH_DONE);
    assign emit   = (ads_pkg::kind_t'(in_reg.kind) == ads_pkg::KIND_TICK) && active;

    // Wrapping ages against the stored timestamps.
    assign since     = in_reg.now_ms - valid_time_reg;
    assign conv_age  = in_reg.now_ms - conv_start_reg;
    assign align_age = in_reg.now_ms - align_start_reg;
    assign dwell_age = in_reg.now_ms - dwell_start_reg;

    // Range selection: fresh valid report first, then the bridged good value.
    assign range_ok  = have_range_reg && range_rvalid_reg &&
                       (since <= TB'(range_tmo_reg));
    assign bridged   = !range_ok && initial_known_reg && (since <= TB'(range_bridge_reg));
    assign xvalid    = range_ok || bridged;
    assign x_sel     = range_ok ? range_x_reg : (bridged ? good_x_reg : '0);
    assign timed_out = !xvalid && (since > TB'(range_tmo_reg));

    // Tolerance tests on magnitudes.
    assign x_in_tol     = ads_pkg::err_mag(x_sel) < EB'(x_tol_reg);
    assign angle_in_tol = ads_pkg::err_mag(held_angle_reg) < EB'(angle_tol_reg);
    assign t_in_tol     = angle_known_reg && angle_in_tol;

    // Next-state logic for the phase machine and held sensor state.
    always_comb begin
        phase_next         = phase_reg;
        have_range_next    = have_range_reg;
        range_rvalid_next  = range_rvalid_reg;
        range_x_next       = range_x_reg;
        valid_time_next    = valid_time_reg;
        good_x_next        = good_x_reg;
        initial_known_next = initial_known_reg;
        initial_range_next = initial_range_reg;
        angle_known_next   = angle_known_reg;
        held_angle_next    = held_angle_reg;
        conv_pending_next  = conv_pending_reg;
        conv_start_next    = conv_start_reg;
        align_start_next   = align_start_reg;
        dwell_start_next   = dwell_start_reg;
        success_next       = success_reg;
        failure_next       = failure_reg;

        unique case (ads_pkg::kind_t'(in_reg.kind))
            ads_pkg::KIND_RANGE: begin
                have_range_next   = 1'b1;
                range_rvalid_next = in_reg.report_valid;
                range_x_next      = in_reg.x_error_in;
                if (in_reg.report_valid) begin
                    valid_time_next = in_reg.now_ms;
                    good_x_next     = in_reg.x_error_in;
                end
            end
            ads_pkg::KIND_ANGLE: begin
                if (in_reg.report_valid) begin
                    held_angle_next  = in_reg.theta_error_in;
                    angle_known_next = 1'b1;
                end
            end
            ads_pkg::KIND_START, ads_pkg::KIND_STOP: begin
                // Both clear the sensor state; start also clears the outcome.
                phase_next         = (ads_pkg::kind_t'(in_reg.kind) == ads_pkg::KIND_START) ?
                                     ads_pkg::PH_APPROACH : ads_pkg::PH_IDLE;
                have_range_next    = 1'b0;
                range_rvalid_next  = 1'b0;
                range_x_next       = '0;
                good_x_next        = '0;
                valid_time_next    = in_reg.now_ms;
                angle_known_next   = 1'b0;
                held_angle_next    = '0;
                initial_known_next = 1'b0;
                initial_range_next = '0;
                conv_pending_next  = 1'b0;
                if (ads_pkg::kind_t'(in_reg.kind) == ads_pkg::KIND_START) begin
                    success_next = 1'b0;
                    failure_next = 1'b0;
                end
            end
            ads_pkg::KIND_TICK: begin
                if (active) begin
                    // The first fresh range of this approach is latched.
                    if (range_ok && !initial_known_reg) begin
                        initial_range_next = range_x_reg;
                        initial_known_next = 1'b1;
                    end
                    unique case (phase_reg)
                        ads_pkg::PH_APPROACH: begin
                            if (timed_out) begin
                                failure_next = 1'b1;
                            end else if (!xvalid || !x_in_tol) begin
                                conv_pending_next = 1'b0;
                            end else if (!conv_pending_reg) begin
                                conv_pending_next = 1'b1;
                                conv_start_next   = in_reg.now_ms;
                            end else if (conv_age >= TB'(conv_hold_reg)) begin
                                if (t_in_tol) begin
                                    phase_next       = ads_pkg::PH_DWELL;
                                    dwell_start_next = in_reg.now_ms;
                                end else begin
                                    phase_next       = ads_pkg::PH_ALIGN;
                                    align_start_next = in_reg.now_ms;
                                end
                            end
                        end
                        ads_pkg::PH_ALIGN: begin
                            if (xvalid && !x_in_tol) begin
                                conv_pending_next = 1'b0;
                                phase_next        = ads_pkg::PH_APPROACH;
                            end else if (timed_out) begin
                                failure_next = 1'b1;
                            end else if (t_in_tol) begin
                                if (xvalid) begin
                                    phase_next       = ads_pkg::PH_DWELL;
                                    dwell_start_next = in_reg.now_ms;
                                end
                            end else if (align_age > TB'(align_tmo_reg)) begin
                                failure_next = 1'b1;
                            end
                        end
                        ads_pkg::PH_DWELL: begin
                            if (timed_out) begin
                                failure_next = 1'b1;
                            end else if (!xvalid || !angle_known_reg) begin
                                dwell_start_next = in_reg.now_ms;
                            end else if (!x_in_tol) begin
                                phase_next        = ads_pkg::PH_APPROACH;
                                conv_pending_next = 1'b0;
                            end else if (!angle_in_tol) begin
                                phase_next       = ads_pkg::PH_ALIGN;
                                align_start_next = in_reg.now_ms;
                            end else if (dwell_age > TB'(dwell_time_reg)) begin
                                phase_next   = ads_pkg::PH_DONE;
                                success_next = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    // Result beat for a tick, showing the phase in which it was handled.
    always_comb begin
        res = '0;
        unique case (phase_reg)
            ads_pkg::PH_APPROACH: begin
                res.phase        = ads_pkg::OPH_APPROACH;
                res.ctrl_publish = 1'b1;
                res.ctrl_valid   = xvalid;
                res.ctrl_x       = x_sel;
            end
            ads_pkg::PH_ALIGN: begin
                res.phase        = ads_pkg::OPH_ALIGN;
                res.ctrl_publish = 1'b1;
                res.ctrl_valid   = 1'b1;
                res.ctrl_x       = '0;
            end
            ads_pkg::PH_DWELL: begin
                res.phase        = ads_pkg::OPH_DWELL;
                res.ctrl_publish = 1'b1;
                res.ctrl_valid   = 1'b0;
                res.ctrl_x       = x_sel;
            end
            default: begin
                res.phase        = ads_pkg::OPH_DONE;
                res.ctrl_publish = 1'b0;
                res.ctrl_valid   = 1'b0;
                res.ctrl_x       = '0;
            end
        endcase
        if (res.ctrl_publish) begin
            res.ctrl_theta        = held_angle_reg;
            res.ctrl_initial_dist = initial_range_next;
        end
        res.range_held = bridged;
        // Failure wins over success, including a decision made on this tick.
        if (failure_next) begin
            res.outcome = ads_pkg::OUT_FAILED;
        end else if (success_next) begin
            res.outcome = ads_pkg::OUT_SUCCEEDED;
        end else begin
            res.outcome = ads_pkg::OUT_RUNNING;
        end
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_tol_reg        <= ads_pkg::X_TOL_RESET;
            angle_tol_reg    <= ads_pkg::ANGLE_TOL_RESET;
            dwell_time_reg   <= ads_pkg::DWELL_TIME_RESET;
            align_tmo_reg    <= ads_pkg::ALIGN_TMO_RESET;
            range_tmo_reg    <= ads_pkg::RANGE_TMO_RESET;
            range_bridge_reg <= ads_pkg::RANGE_BRIDGE_RESET;
            conv_hold_reg    <= ads_pkg::CONV_HOLD_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (ads_pkg::cfg_index_t'(cfg_index))
                ads_pkg::CFG_X_TOL:        x_tol_reg        <= cfg_data[TL-1:0];
                ads_pkg::CFG_ANGLE_TOL:    angle_tol_reg    <= cfg_data[TL-1:0];
                ads_pkg::CFG_DWELL_TIME:   dwell_time_reg   <= cfg_data[MB-1:0];
                ads_pkg::CFG_ALIGN_TMO:    align_tmo_reg    <= cfg_data[MB-1:0];
                ads_pkg::CFG_RANGE_TMO:    range_tmo_reg    <= cfg_data[MB-1:0];
                ads_pkg::CFG_RANGE_BRIDGE: range_bridge_reg <= cfg_data[MB-1:0];
                ads_pkg::CFG_CONV_HOLD:    conv_hold_reg    <= cfg_data[MB-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && emit) begin
            out_reg <= res;
        end
    end

    // Supervisor state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= ads_pkg::PH_IDLE;
            have_range_reg    <= 1'b0;
            range_rvalid_reg  <= 1'b0;
            range_x_reg       <= '0;
            valid_time_reg    <= '0;
            good_x_reg        <= '0;
            initial_known_reg <= 1'b0;
            initial_range_reg <= '0;
            angle_known_reg   <= 1'b0;
            held_angle_reg    <= '0;
            conv_pending_reg  <= 1'b0;
            conv_start_reg    <= '0;
            align_start_reg   <= '0;
            dwell_start_reg   <= '0;
            success_reg       <= 1'b0;
            failure_reg       <= 1'b0;
        end else if (step) begin
            phase_reg         <= phase_next;
            have_range_reg    <= have_range_next;
            range_rvalid_reg  <= range_rvalid_next;
            range_x_reg       <= range_x_next;
            valid_time_reg    <= valid_time_next;
            good_x_reg        <= good_x_next;
            initial_known_reg <= initial_known_next;
            initial_range_reg <= initial_range_next;
            angle_known_reg   <= angle_known_next;
            held_angle_reg    <= held_angle_next;
            conv_pending_reg  <= conv_pending_next;
            conv_start_reg    <= conv_start_next;
            align_start_reg   <= align_start_next;
            dwell_start_reg   <= dwell_start_next;
            success_reg       <= success_next;
            failure_reg       <= failure_next;
        end
    end

endmodule

// File: tb/ads_report_checker.sv
// ----------------------------------------------------------------------------
// ads_report_checker
// Watches the event, result and configuration channels of the approach
// docking supervisor, predicts every result beat from the accepted event
// beats and compares each accepted result field by field.
// ----------------------------------------------------------------------------
module ads_report_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  ads_pkg::in_beat_t                  s_data,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  ads_pkg::out_beat_t                 m_data,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [ads_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [ads_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output int                                 fault_count,
    output int                                 reports_due
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ERROR_BITS = ads_pkg::ERROR_BITS;
    localparam int TIME_BITS  = ads_pkg::TIME_BITS;
    localparam int TOL_BITS   = ads_pkg::TOL_BITS;
    localparam int MS_BITS    = ads_pkg::MS_BITS;

    // Shadow copy of the tolerance and timing registers.
    logic [TOL_BITS-1:0] x_tol, angle_tol;
    logic [MS_BITS-1:0]  dwell_ms, align_tmo_ms, range_tmo_ms, bridge_ms, conv_hold_ms;

    // Shadow copy of the supervisor state.
    ads_pkg::phase_t              phase_now;
    logic                         have_range, range_ok, initial_seen, angle_seen;
    logic                         converging, succeeded, failed;
    logic signed [ERROR_BITS-1:0] range_x, last_good_x, initial_x, angle_x;
    logic [TIME_BITS-1:0]         range_time, converge_time, align_time, dwell_time;

    ads_pkg::out_beat_t expected_reports[$];

    // Magnitude of a Q4.12 error, one bit wider so the most negative code fits.
    function automatic logic [ERROR_BITS:0] err_size(input logic signed [ERROR_BITS-1:0] v);
        logic signed [ERROR_BITS:0] w;
        w = v;
        return (w < 0) ? -w : w;
    endfunction

    // Start, stop and reset all forget the sensor picture.
    task automatic forget_sensors(input logic [TIME_BITS-1:0] t);
        have_range   = 1'b0;
        range_ok     = 1'b0;
        range_x      = '0;
        last_good_x  = '0;
        range_time   = t;
        angle_seen   = 1'b0;
        angle_x      = '0;
        initial_seen = 1'b0;
        initial_x    = '0;
        converging   = 1'b0;
    endtask

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fault_count++;
        end
    endtask

    // Applies one event beat to the shadow state and queues the result that
    // a tick outside idle produces.
    task automatic absorb_event(input ads_pkg::in_beat_t ev);
        logic [TIME_BITS-1:0]         since, elapsed;
        logic signed [ERROR_BITS-1:0] x, cx;
        logic                         xvalid, held, timed_out, x_ok, t_ok, publish, cvalid;
        ads_pkg::out_beat_t           res;
        since   = ev.now_ms - range_time;
        x       = '0;
        xvalid  = 1'b0;
        held    = 1'b0;
        publish = 1'b1;
        cvalid  = 1'b0;
        res     = '0;
        if (ev.kind == ads_pkg::KIND_RANGE) begin
            have_range = 1'b1;
            range_ok   = ev.report_valid;
            range_x    = ev.x_error_in;
            if (ev.report_valid) begin
                range_time  = ev.now_ms;
                last_good_x = ev.x_error_in;
            end
        end else if (ev.kind == ads_pkg::KIND_ANGLE) begin
            if (ev.report_valid) begin
                angle_x    = ev.theta_error_in;
                angle_seen = 1'b1;
            end
        end else if (ev.kind == ads_pkg::KIND_START) begin
            phase_now = ads_pkg::PH_APPROACH;
            forget_sensors(ev.now_ms);
            succeeded = 1'b0;
            failed    = 1'b0;
        end else if (ev.kind == ads_pkg::KIND_STOP) begin
            phase_now = ads_pkg::PH_IDLE;
            forget_sensors(ev.now_ms);
        end else if (ev.kind == ads_pkg::KIND_TICK && phase_now != ads_pkg::PH_IDLE) begin
            // Pick the range: a fresh valid report, else the bridged good value.
            if (have_range && range_ok && since <= range_tmo_ms) begin
                x      = range_x;
                xvalid = 1'b1;
                if (!initial_seen) begin
                    initial_x    = range_x;
                    initial_seen = 1'b1;
                end
            end else if (initial_seen && since <= bridge_ms) begin
                x      = last_good_x;
                xvalid = 1'b1;
                held   = 1'b1;
            end
            timed_out = !xvalid && since > range_tmo_ms;
            x_ok      = err_size(x) < x_tol;
            t_ok      = angle_seen && err_size(angle_x) < angle_tol;
            cx        = x;

            // Phase decisions on this tick.
            case (phase_now)
                ads_pkg::PH_APPROACH: begin
                    res.phase = ads_pkg::OPH_APPROACH;
                    cvalid    = xvalid;
                    elapsed   = ev.now_ms - converge_time;
                    if (timed_out) begin
                        failed = 1'b1;
                    end else if (!xvalid || !x_ok) begin
                        converging = 1'b0;
                    end else if (!converging) begin
                        converging    = 1'b1;
                        converge_time = ev.now_ms;
                    end else if (elapsed >= conv_hold_ms) begin
                        if (t_ok) begin
                            phase_now  = ads_pkg::PH_DWELL;
                            dwell_time = ev.now_ms;
                        end else begin
                            phase_now  = ads_pkg::PH_ALIGN;
                            align_time = ev.now_ms;
                        end
                    end
                end
                ads_pkg::PH_ALIGN: begin
                    res.phase = ads_pkg::OPH_ALIGN;
                    cx        = '0;
                    cvalid    = 1'b1;
                    elapsed   = ev.now_ms - align_time;
                    if (xvalid && !x_ok) begin
                        converging = 1'b0;
                        phase_now  = ads_pkg::PH_APPROACH;
                    end else if (timed_out) begin
                        failed = 1'b1;
                    end else if (t_ok) begin
                        if (xvalid) begin
                            phase_now  = ads_pkg::PH_DWELL;
                            dwell_time = ev.now_ms;
                        end
                    end else if (elapsed > align_tmo_ms) begin
                        failed = 1'b1;
                    end
                end
                ads_pkg::PH_DWELL: begin
                    res.phase = ads_pkg::OPH_DWELL;
                    elapsed   = ev.now_ms - dwell_time;
                    if (timed_out) begin
                        failed = 1'b1;
                    end else if (!xvalid || !angle_seen) begin
                        dwell_time = ev.now_ms;
                    end else if (!x_ok) begin
                        phase_now  = ads_pkg::PH_APPROACH;
                        converging = 1'b0;
                    end else if (err_size(angle_x) >= angle_tol) begin
                        phase_now  = ads_pkg::PH_ALIGN;
                        align_time = ev.now_ms;
                    end else if (elapsed > dwell_ms) begin
                        phase_now = ads_pkg::PH_DONE;
                        succeeded = 1'b1;
                    end
                end
                default: begin
                    res.phase = ads_pkg::OPH_DONE;
                    publish   = 1'b0;
                end
            endcase

            res.ctrl_publish      = publish;
            res.ctrl_valid        = publish && cvalid;
            res.ctrl_x            = publish ? cx : '0;
            res.ctrl_theta        = publish ? angle_x : '0;
            res.ctrl_initial_dist = publish ? initial_x : '0;
            res.range_held        = held;
            res.outcome           = failed ? ads_pkg::OUT_FAILED :
                                    (succeeded ? ads_pkg::OUT_SUCCEEDED : ads_pkg::OUT_RUNNING);
            expected_reports = {expected_reports, res};
        end
    endtask

    // Everything is sampled at the rising edge, before the block updates.
    always @(posedge aclk) begin
        ads_pkg::out_beat_t want;
        if (!aresetn) begin
            x_tol         = ads_pkg::X_TOL_RESET;
            angle_tol     = ads_pkg::ANGLE_TOL_RESET;
            dwell_ms      = ads_pkg::DWELL_TIME_RESET;
            align_tmo_ms  = ads_pkg::ALIGN_TMO_RESET;
            range_tmo_ms  = ads_pkg::RANGE_TMO_RESET;
            bridge_ms     = ads_pkg::RANGE_BRIDGE_RESET;
            conv_hold_ms  = ads_pkg::CONV_HOLD_RESET;
            phase_now     = ads_pkg::PH_IDLE;
            forget_sensors('0);
            converge_time = '0;
            align_time    = '0;
            dwell_time    = '0;
            succeeded     = 1'b0;
            failed        = 1'b0;
            expected_reports.delete();
            fault_count   = 0;
        end else begin
            // Register writes.
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    ads_pkg::CFG_X_TOL:        x_tol        = cfg_data[TOL_BITS-1:0];
                    ads_pkg::CFG_ANGLE_TOL:    angle_tol    = cfg_data[TOL_BITS-1:0];
                    ads_pkg::CFG_DWELL_TIME:   dwell_ms     = cfg_data;
                    ads_pkg::CFG_ALIGN_TMO:    align_tmo_ms = cfg_data;
                    ads_pkg::CFG_RANGE_TMO:    range_tmo_ms = cfg_data;
                    ads_pkg::CFG_RANGE_BRIDGE: bridge_ms    = cfg_data;
                    ads_pkg::CFG_CONV_HOLD:    conv_hold_ms = cfg_data;
                    default: ;
                endcase
            end

            // Result beats are compared before this edge's event is absorbed.
            if (m_valid && m_ready) begin
                if (expected_reports.size() == 0) begin
                    $error("result beat arrived with no result expected");
                    fault_count++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("phase", want.phase, m_data.phase);
                    check_field("ctrl_publish", want.ctrl_publish, m_data.ctrl_publish);
                    check_field("ctrl_valid", want.ctrl_valid, m_data.ctrl_valid);
                    check_field("ctrl_x", $signed(want.ctrl_x), $signed(m_data.ctrl_x));
                    check_field("ctrl_theta", $signed(want.ctrl_theta),
                                $signed(m_data.ctrl_theta));
                    check_field("ctrl_initial_dist", $signed(want.ctrl_initial_dist),
                                $signed(m_data.ctrl_initial_dist));
                    check_field("range_held", want.range_held, m_data.range_held);
                    check_field("outcome", want.outcome, m_data.outcome);
                end
            end

            if (s_valid && s_ready)
                absorb_event(s_data);
        end
        reports_due = expected_reports.size();
    end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the approach docking supervisor with a directed sequence through
// the approach, dwell and done phases and every outcome, a back-pressure burst,
// and random approach episodes under several register settings; the checker
// beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ERROR_BITS     = ads_pkg::ERROR_BITS;
    localparam int TIME_BITS      = ads_pkg::TIME_BITS;
    localparam int TOL_BITS       = ads_pkg::TOL_BITS;
    localparam int KIND_BITS      = ads_pkg::KIND_BITS;
    localparam int CFG_INDEX_BITS = ads_pkg::CFG_INDEX_BITS;
    localparam int CFG_DATA_BITS  = ads_pkg::CFG_DATA_BITS;

    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int PIPE_CYCLES   = 4;
    localparam int RANDOM_EVENTS = 1200;
    localparam int CONFIG_ROUNDS = 8;
    localparam int BURST_TICKS   = 40;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE     = 3'd7;
    localparam logic [KIND_BITS-1:0]      KIND_SPARE_LO = 3'd5;
    localparam logic [KIND_BITS-1:0]      KIND_SPARE_HI = 3'd7;
    localparam logic [TIME_BITS-1:0]      WRAP_START    = 32'hFFFF_FF00;

    logic                      aclk;
    logic                      aresetn   = 1'b0;
    logic                      s_valid   = 1'b0;
    logic                      s_ready;
    ads_pkg::in_beat_t         s_data    = '0;
    logic                      m_valid;
    logic                      m_ready   = 1'b0;
    ads_pkg::out_beat_t        m_data;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

    int fault_count;
    int reports_due;
    int events_sent   = 0;
    int hold_requests = 0;
    bit quiet         = 1'b0;

    logic [TIME_BITS-1:0] clk_ms;
    logic [TOL_BITS-1:0]  x_tol_now = ads_pkg::X_TOL_RESET;
    logic [TOL_BITS-1:0]  a_tol_now = ads_pkg::ANGLE_TOL_RESET;

    approach_docking_supervisor_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ads_report_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fault_count (fault_count),
        .reports_due (reports_due)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, 18);
    endfunction

    // Random Q4.12 error: inside the tolerance, on its edge, or anywhere.
    function automatic logic signed [ERROR_BITS-1:0] pick_err(input logic [TOL_BITS-1:0] tol,
                                                             input int good_pct);
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < good_pct)
            v = (tol == 0) ? 0 : int'($urandom_range(0, int'(tol) - 1));
        else if (r < good_pct + (100 - good_pct) / 2)
            v = int'(tol) - int'($urandom_range(0, 1));
        else
            return ERROR_BITS'($urandom);
        if ($urandom_range(0, 1) == 1)
            v = -v;
        return ERROR_BITS'(v);
    endfunction

    // Mostly short steps, sometimes long enough to time out, rarely a jump
    // anywhere, which may run backwards.
    function automatic logic [TIME_BITS-1:0] next_time(input logic [TIME_BITS-1:0] t);
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return t + $urandom_range(0, 100);
        else if (r < 85)
            return t + $urandom_range(0, 700);
        else if (r < 95)
            return t + $urandom_range(0, 4000);
        else if (r < 99)
            return t + $urandom_range(0, 70000);
        return $urandom;
    endfunction

    // One event beat; valid stays up across back-to-back beats.
    task automatic send_event(input logic [KIND_BITS-1:0] kind, input logic [TIME_BITS-1:0] t,
                              input logic vld, input logic signed [ERROR_BITS-1:0] x,
                              input logic signed [ERROR_BITS-1:0] th);
        int                gap;
        ads_pkg::in_beat_t beat;
        gap                 = draw_gap();
        beat.kind           = kind;
        beat.now_ms         = t;
        beat.report_valid   = vld;
        beat.x_error_in     = x;
        beat.theta_error_in = th;
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data  = beat;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (kind <= ads_pkg::KIND_STOP)
            events_sent++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        cfg_index = idx;
        cfg_data  = value;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Pause the sender until every expected result has come, then let the
    // pipeline empty of beats that cause no result.
    task automatic drain();
        s_valid = 1'b0;
        while (reports_due != 0) @(negedge aclk);
        repeat (PIPE_CYCLES) @(negedge aclk);
    endtask

    // A start followed by a random mix of reports and ticks.
    task automatic run_episode();
        int                   good_pct;
        int                   steps;
        int                   r;
        logic [KIND_BITS-1:0] k;
        r        = $urandom_range(0, 2);
        good_pct = (r == 0) ? 50 : ((r == 1) ? 85 : 97);
        quiet    = ($urandom_range(0, 4) == 0);
        steps    = $urandom_range(10, 60);
        clk_ms   = next_time(clk_ms);
        send_event(ads_pkg::KIND_START, clk_ms, 1'($urandom), ERROR_BITS'($urandom),
                   ERROR_BITS'($urandom));
        repeat (steps) begin
            r      = $urandom_range(0, 99);
            clk_ms = next_time(clk_ms);
            if (r < 45)
                k = ads_pkg::KIND_TICK;
            else if (r < 73)
                k = ads_pkg::KIND_RANGE;
            else if (r < 90)
                k = ads_pkg::KIND_ANGLE;
            else if (r < 93)
                k = KIND_BITS'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
            else if (r < 95)
                k = ads_pkg::KIND_START;
            else if (r < 97)
                k = ads_pkg::KIND_STOP;
            else
                k = ads_pkg::KIND_TICK;
            send_event(k, clk_ms, ($urandom_range(0, 99) < 88), pick_err(x_tol_now, good_pct),
                       pick_err(a_tol_now, good_pct));
        end
        if ($urandom_range(0, 9) < 6)
            send_event(ads_pkg::KIND_STOP, clk_ms, 1'($urandom), ERROR_BITS'($urandom),
                       ERROR_BITS'($urandom));
        quiet = 1'b0;
    endtask

    // Result side: a random stall per beat, and a long hold-off on request.
    initial begin
        int gap;
        int holds_taken;
        holds_taken = 0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (holds_taken < hold_requests) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                holds_taken++;
            end
            gap = draw_gap();
            if (gap > 0) begin
                m_ready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    // Watchdog: ends the run when no beat moves on any channel for too long.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    // Stimulus and verdict.
    initial begin
        int                       target;
        logic [CFG_DATA_BITS-1:0] v_xtol, v_atol, v_dwell, v_align, v_rtmo, v_bridge, v_hold;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // The spare register index is dropped by the block.
        write_reg(CFG_SPARE, CFG_DATA_BITS'($urandom));

        // Directed: idle behaviour and ignored kinds.
        send_event(ads_pkg::KIND_TICK, '0, 1'b1, '0, '0);
        send_event(KIND_SPARE_LO, '0, 1'b1, 16'sh7FFF, 16'sh7FFF);
        send_event(KIND_BITS'(KIND_SPARE_LO + 1), '1, 1'b0, 16'sh8000, 16'sh8000);
        send_event(KIND_SPARE_HI, '1, 1'b1, '1, '1);
        send_event(ads_pkg::KIND_RANGE, 32'd10, 1'b1, 16'sh7FFF, '0);
        send_event(ads_pkg::KIND_ANGLE, 32'd10, 1'b0, '0, 16'sh7FFF);

        // Directed: approach just before the timestamp wraps, no range yet.
        send_event(ads_pkg::KIND_START, WRAP_START, 1'b0, '0, '0);
        send_event(ads_pkg::KIND_TICK, WRAP_START, 1'b0, '0, '0);
        // Extreme ranges; the first valid one becomes the initial distance.
        send_event(ads_pkg::KIND_RANGE, WRAP_START + 10, 1'b1, 16'sh8000, '0);
        send_event(ads_pkg::KIND_TICK, WRAP_START + 10, 1'b0, '0, '0);
        send_event(ads_pkg::KIND_RANGE, WRAP_START + 15, 1'b1, 16'sh7FFF, '0);
        send_event(ads_pkg::KIND_TICK, WRAP_START + 15, 1'b0, '0, '0);
        // Converge across the wrap, go straight to dwell, then succeed.
        send_event(ads_pkg::KIND_RANGE, WRAP_START + 20, 1'b1, '0, '0);
        send_event(ads_pkg::KIND_ANGLE, WRAP_START + 20, 1'b1, '0, '0);
        send_event(ads_pkg::KIND_TICK, WRAP_START + 20, 1'b0, '0, '0);
        send_event(ads_pkg::KIND_TICK, WRAP_START + 600, 1'b0, '0, '0);
        send_event(ads_pkg::KIND_TICK, WRAP_START + 700, 1'b0, '0, '0);
        send_event(ads_pkg::KIND_RANGE, WRAP_START + 2600, 1'b1, '0, '0);
        send_event(ads_pkg::KIND_TICK, WRAP_START + 2701, 1'b0, '0, '0);
        // In done: a lapsed range is bridged, then lost without a failure.
        send_event(ads_pkg::KIND_RANGE, WRAP_START + 2750, 1'b0, 16'sh1234, '0);
        send_event(ads_pkg::KIND_TICK, WRAP_START + 2800, 1'b0, '0, '0);
        send_event(ads_pkg::KIND_ANGLE, WRAP_START + 2810, 1'b1, '0, 16'sh8000);
        send_event(ads_pkg::KIND_TICK, WRAP_START + 4700, 1'b0, '0, '0);
        // A fresh start with no range times out and the failure sticks.
        send_event(ads_pkg::KIND_START, WRAP_START + 5000, 1'b1, '0, '0);
        send_event(ads_pkg::KIND_TICK, WRAP_START + 7001, 1'b0, '0, '0);
        send_event(ads_pkg::KIND_TICK, WRAP_START + 7002, 1'b0, '0, '0);
        send_event(ads_pkg::KIND_STOP, WRAP_START + 7003, 1'b0, '0, '0);
        send_event(ads_pkg::KIND_TICK, WRAP_START + 7004, 1'b0, '0, '0);
        clk_ms = WRAP_START + 7004;

        // Back-pressure: the result side holds off while ticks keep coming.
        hold_requests++;
        quiet = 1'b1;
        send_event(ads_pkg::KIND_START, clk_ms, 1'b1, '0, '0);
        send_event(ads_pkg::KIND_RANGE, clk_ms, 1'b1, '0, '0);
        repeat (BURST_TICKS) send_event(ads_pkg::KIND_TICK, clk_ms, 1'b0, '0, '0);
        quiet = 1'b0;

        // Random episodes under a series of register settings.
        for (int round = 0; round < CONFIG_ROUNDS; round++) begin
            drain();
            if (round == 0) begin
                {v_xtol, v_atol, v_dwell, v_align, v_rtmo, v_bridge, v_hold} = '0;
            end else if (round == 1) begin
                {v_xtol, v_atol, v_dwell, v_align, v_rtmo, v_bridge, v_hold} = '1;
            end else begin
                v_xtol   = CFG_DATA_BITS'($urandom_range(20, 3000));
                v_atol   = CFG_DATA_BITS'($urandom_range(20, 3000));
                v_dwell  = CFG_DATA_BITS'($urandom_range(0, 2500));
                v_align  = CFG_DATA_BITS'($urandom_range(0, 4000));
                v_rtmo   = CFG_DATA_BITS'($urandom_range(100, 3000));
                v_bridge = CFG_DATA_BITS'($urandom_range(0, 600));
                v_hold   = CFG_DATA_BITS'($urandom_range(0, 1000));
            end
            write_reg(ads_pkg::CFG_X_TOL, v_xtol);
            write_reg(ads_pkg::CFG_ANGLE_TOL, v_atol);
            write_reg(ads_pkg::CFG_DWELL_TIME, v_dwell);
            write_reg(ads_pkg::CFG_ALIGN_TMO, v_align);
            write_reg(ads_pkg::CFG_RANGE_TMO, v_rtmo);
            write_reg(ads_pkg::CFG_RANGE_BRIDGE, v_bridge);
            write_reg(ads_pkg::CFG_CONV_HOLD, v_hold);
            x_tol_now = v_xtol[TOL_BITS-1:0];
            a_tol_now = v_atol[TOL_BITS-1:0];
            target    = events_sent + RANDOM_EVENTS / CONFIG_ROUNDS;
            while (events_sent < target) run_episode();
        end

        drain();
        repeat (PIPE_CYCLES) @(negedge aclk);
        if (fault_count == 0 && reports_due == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: approach_docking_supervisor_unit.f
rtl/core/ads_pkg.sv
rtl/core/approach_docking_supervisor_unit.sv
tb/ads_report_checker.sv
tb/testbench.sv
